[sv/shrp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 sharpen filter.
// Depends on nothing; every other file of the block imports it.

package shrp_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAN_W     = 3;
    localparam int ROW_W      = 12;
    // Signed width of 5*centre minus four neighbors (-1020..1275).
    localparam int ACC_W      = 12;

    // Defaults of the top-level parameters.
    localparam int MAX_WIDTH_DEFAULT    = 2048;
    localparam int MAX_CHANNELS_DEFAULT = 4;

    // Smallest legal image width and height.
    localparam int MIN_DIM = 3;

    localparam int KERNEL_CENTRE = 5;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CHAN_W-1:0]     CHAN_RESET   = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_DRAIN  = 1'b1
    } req_type_t;

    // Control flags of one accepted item, passed from the sequencer to the datapath.
    typedef struct packed {
        logic is_sample;   // pixel sample that updates the line stores
        logic has_result;  // item produces one output transfer
        logic interior;    // output is computed, not a border zero
        logic frame_last;  // final output of the frame
    } shrp_item_t;

endpackage

[sv/shrp_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on shrp_pkg for its default width and depth.

module shrp_ram
    import shrp_pkg::*;
#(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = MAX_WIDTH_DEFAULT * MAX_CHANNELS_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/shrp_seq.sv]
`timescale 1ns / 1ps
// Sequencer of the sharpen filter: configuration registers, row and sample
// counters, line store addresses and per-item control flags. Depends on shrp_pkg.

module shrp_seq
    import shrp_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEFAULT,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT,
    localparam int LINE_DEPTH  = MAX_WIDTH * MAX_CHANNELS,
    localparam int ADDR_W      = $clog2(LINE_DEPTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_accept,
    input  req_type_t             req_type,
    output shrp_item_t            item,
    output logic [ADDR_W-1:0]     cur_addr,
    output logic [ADDR_W-1:0]     look_addr,
    output logic [CHAN_W-1:0]     chans
);

    localparam int LEN_W = $clog2(LINE_DEPTH + 1);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [CHAN_W-1:0]     chan_reg;
    logic [ADDR_W-1:0]     index_reg;
    logic [ADDR_W-1:0]     index_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic                  draining_reg;
    logic                  draining_next;

    logic [W_W-1:0]        eff_width;
    logic [CHAN_W-1:0]     eff_chans;
    logic [CFG_DATA_W-1:0] eff_height;
    logic [LEN_W-1:0]      row_len;
    logic [LEN_W:0]        index_inc;
    logic [LEN_W:0]        ahead;
    logic [ROW_W-1:0]      row_inc;
    logic                  row_end;
    logic                  is_drain;
    logic                  cfg_hit;

    // Registers are clamped to their legal ranges before use.
    always_comb
    begin
        if (width_reg < CFG_DATA_W'(MIN_DIM))
        begin
            eff_width = W_W'(MIN_DIM);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_width = W_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = W_W'(width_reg);
        end

        if (chan_reg == '0)
        begin
            eff_chans = CHAN_W'(1);
        end
        else if (int'(chan_reg) > MAX_CHANNELS)
        begin
            eff_chans = CHAN_W'(MAX_CHANNELS);
        end
        else
        begin
            eff_chans = chan_reg;
        end

        if (height_reg < CFG_DATA_W'(MIN_DIM))
        begin
            eff_height = CFG_DATA_W'(MIN_DIM);
        end
        else
        begin
            eff_height = height_reg;
        end
    end

    assign row_len   = LEN_W'(eff_width) * LEN_W'(eff_chans);
    assign index_inc = (LEN_W + 1)'(index_reg) + (LEN_W + 1)'(1);
    assign ahead     = (LEN_W + 1)'(index_reg) + (LEN_W + 1)'(eff_chans);
    assign row_end   = index_inc >= (LEN_W + 1)'(row_len);
    assign row_inc   = row_reg + ROW_W'(1);
    assign is_drain  = (req_type == REQ_DRAIN);

    // The right-hand neighbor is fetched one pixel ahead; past the row end the
    // address wraps to the head of the row, which was written earlier in it.
    always_comb
    begin
        if (ahead >= (LEN_W + 1)'(row_len))
        begin
            look_addr = ADDR_W'(ahead - (LEN_W + 1)'(row_len));
        end
        else
        begin
            look_addr = ADDR_W'(ahead);
        end
    end

    assign cur_addr = index_reg;
    assign chans    = eff_chans;

    always_comb
    begin
        item.is_sample  = !is_drain && !draining_reg;
        item.has_result = is_drain ? draining_reg : (!draining_reg && (row_reg != '0));
        item.interior   = !is_drain && !draining_reg && (row_reg >= ROW_W'(2))
                          && ((LEN_W + 1)'(index_reg) >= (LEN_W + 1)'(eff_chans))
                          && (ahead < (LEN_W + 1)'(row_len));
        item.frame_last = is_drain && draining_reg && row_end;
    end

    always_comb
    begin
        unique case (cfg_index_t'(cfg_index))
            CFG_IMAGE_WIDTH,
            CFG_IMAGE_HEIGHT,
            CFG_CHANNEL_COUNT: cfg_hit = cfg_valid;
            default:           cfg_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        index_next    = index_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        priority if (cfg_hit)
        begin
            index_next    = '0;
            row_next      = '0;
            draining_next = 1'b0;
        end
        else if (in_accept && is_drain && draining_reg)
        begin
            if (row_end)
            begin
                index_next    = '0;
                row_next      = '0;
                draining_next = 1'b0;
            end
            else
            begin
                index_next = ADDR_W'(index_inc);
            end
        end
        else if (in_accept && !is_drain && !draining_reg)
        begin
            if (row_end)
            begin
                index_next = '0;
                row_next   = row_inc;
                if (row_inc >= eff_height)
                begin
                    draining_next = 1'b1;
                end
            end
            else
            begin
                index_next = ADDR_W'(index_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            chan_reg     <= CHAN_RESET;
            index_reg    <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            index_reg    <= index_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
            if (cfg_valid)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                    CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[CHAN_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

[sv/shrp_core.sv]
`timescale 1ns / 1ps
// Datapath of the sharpen filter: item register, neighbor shift line, kernel
// arithmetic with clamping, and the output register. Depends on shrp_pkg.

module shrp_core
    import shrp_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEFAULT,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT,
    localparam int LINE_DEPTH  = MAX_WIDTH * MAX_CHANNELS,
    localparam int ADDR_W      = $clog2(LINE_DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_accept,
    input  shrp_item_t          item,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [ADDR_W-1:0]   cur_addr,
    input  logic [CHAN_W-1:0]   chans,
    input  logic [SAMPLE_W-1:0] newer_rd,
    input  logic [SAMPLE_W-1:0] older_rd,
    output logic                in_ready,
    output logic                line_wr_en,
    output logic [ADDR_W-1:0]   line_wr_addr,
    output logic [SAMPLE_W-1:0] newer_wr_data,
    output logic [SAMPLE_W-1:0] older_wr_data,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    localparam int TAPS  = 2 * MAX_CHANNELS;
    localparam int TAP_W = $clog2(TAPS);

    logic                s1_valid_reg;
    shrp_item_t          s1_item_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [SAMPLE_W-1:0] line_reg [TAPS];
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_last_reg;

    logic                advance;
    logic                load;
    logic [TAP_W-1:0]    centre_tap;
    logic [TAP_W-1:0]    left_tap;
    logic [SAMPLE_W-1:0] centre;
    logic [SAMPLE_W-1:0] left;
    logic [ACC_W-1:0]    acc;
    logic [SAMPLE_W-1:0] clamped;
    logic [SAMPLE_W-1:0] result;

    // An item leaves the item register unless it has a result and the output
    // register is full and stalled.
    assign advance  = s1_valid_reg
                      && (!s1_item_reg.has_result || !out_valid_reg || m_axis_tready);
    assign in_ready = !s1_valid_reg || advance;
    assign load     = in_accept && (item.is_sample || item.has_result);

    // The shift line holds the previous row's samples, newest first, fetched one
    // pixel ahead: the centre sits one pixel back and the left neighbor two.
    assign centre_tap = TAP_W'(chans) - TAP_W'(1);
    assign left_tap   = TAP_W'({chans, 1'b0}) - TAP_W'(1);
    assign centre     = line_reg[centre_tap];
    assign left       = line_reg[left_tap];

    // Two's complement wrap is harmless: the true value fits in ACC_W signed bits.
    assign acc = ACC_W'(centre) * ACC_W'(KERNEL_CENTRE)
                 - ACC_W'(older_rd) - ACC_W'(s1_sample_reg)
                 - ACC_W'(left) - ACC_W'(newer_rd);

    always_comb
    begin
        if (acc[ACC_W-1])
        begin
            clamped = '0;
        end
        else if (acc[ACC_W-2:SAMPLE_W] != '0)
        begin
            clamped = '1;
        end
        else
        begin
            clamped = acc[SAMPLE_W-1:0];
        end
    end

    assign result = s1_item_reg.interior ? clamped : '0;

    assign line_wr_en    = advance && s1_item_reg.is_sample;
    assign line_wr_addr  = s1_addr_reg;
    assign newer_wr_data = s1_sample_reg;
    assign older_wr_data = centre;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance && s1_item_reg.has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_item_reg   <= item;
            s1_sample_reg <= sample;
            s1_addr_reg   <= cur_addr;
        end

        if (advance && s1_item_reg.is_sample)
        begin
            line_reg[0] <= newer_rd;
            for (int k = 1; k < TAPS; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end

        if (advance && s1_item_reg.has_result)
        begin
            out_data_reg <= result;
            out_last_reg <= s1_item_reg.frame_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[sv/sharpen_3x3_filter.sv]
`timescale 1ns / 1ps
// Top level of the streaming 3x3 cross-shaped sharpen filter.
// Depends on shrp_pkg, shrp_ram, shrp_seq and shrp_core.

// The filter takes one channel sample per transfer in raster order, channels
// interleaved, and returns 5*centre minus the four neighbors one pixel away,
// clamped to 0..255, per channel; the first and last row and column give zero.
// Output lags input by one row: the first row produces no transfers, and after
// the last row a drain item (tuser high) is sent for every sample of the final,
// all-zero output row, whose last transfer carries tlast and restarts the frame.
// Samples sent while draining and drain items sent otherwise are dropped. The
// block takes one item per clock while the output does not stall. An item's
// result passes from the item register into the output register, which
// hands it on while tready is high. While a result waits in the output register the item
// register still takes one more item; the input stalls only when that item also
// has a result to deliver. The rate is set by the two line stores, which each do
// one read and one write per cycle: the previous row is fetched one pixel ahead
// into a short shift line, and the row before it is read at the current
// position. The line stores need no clearing after reset. Write the
// configuration only while the block is idle; any write of a known register
// restarts the frame.

module sharpen_3x3_filter
    import shrp_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEFAULT,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [7:0] sample
    input  logic                  s_axis_tuser,   // [0] req_type (1 = drain)
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]   m_axis_tdata,   // [7:0] pixel_out
    output logic                  m_axis_tlast    // frame_last
);

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    logic                in_accept;
    shrp_item_t          item;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   look_addr;
    logic [CHAN_W-1:0]   chans;
    logic                line_rd_en;
    logic [SAMPLE_W-1:0] newer_rd;
    logic [SAMPLE_W-1:0] older_rd;
    logic                line_wr_en;
    logic [ADDR_W-1:0]   line_wr_addr;
    logic [SAMPLE_W-1:0] newer_wr_data;
    logic [SAMPLE_W-1:0] older_wr_data;

    // Configuration is taken in every cycle.
    assign cfg_ready  = 1'b1;
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    // Only samples that enter the frame touch the line stores. Their read data
    // stays put until the next such transfer, which also covers a stalled item.
    assign line_rd_en = in_accept && item.is_sample;

    shrp_seq #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .req_type  (req_type_t'(s_axis_tuser)),
        .item      (item),
        .cur_addr  (cur_addr),
        .look_addr (look_addr),
        .chans     (chans)
    );

    // Newer line: the previous row, read one pixel ahead of the current position.
    shrp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_newer_line (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (newer_wr_data),
        .rd_en   (line_rd_en),
        .rd_addr (look_addr),
        .rd_data (newer_rd)
    );

    // Older line: the row before that, read at the current position.
    shrp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_older_line (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (older_wr_data),
        .rd_en   (line_rd_en),
        .rd_addr (cur_addr),
        .rd_data (older_rd)
    );

    shrp_core #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_accept),
        .item          (item),
        .sample        (s_axis_tdata),
        .cur_addr      (cur_addr),
        .chans         (chans),
        .newer_rd      (newer_rd),
        .older_rd      (older_rd),
        .in_ready      (s_axis_tready),
        .line_wr_en    (line_wr_en),
        .line_wr_addr  (line_wr_addr),
        .newer_wr_data (newer_wr_data),
        .older_wr_data (older_wr_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // The final output of a frame belongs to the zero border row.
    a_last_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("frame end carries a nonzero sample");

    // With the output register empty nothing may hold back the input side.
    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    // A write of a known register restarts the frame at its first sample.
    a_cfg_restart : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index <= CFG_CHANNEL_COUNT) |=> cur_addr == '0)
        else $error("configuration write did not restart the frame");
`endif

endmodule
